// ===== design/wke_pkg.sv =====
// ----------------------------------------------------------------------------
// wke_pkg: shared types and constants for the Wendland C2 kernel evaluator
// Formats, divider geometry and the record passed between divider steps.
// ----------------------------------------------------------------------------
`default_nettype none

package wke_pkg;

  // Spatial dimensions of the kernel normalization.
  localparam int Dimensions = 3;

  // Q2.29 working format for q and 2-q.
  localparam int FracBits = 29;
  localparam logic [31:0] Q29One = 32'h2000_0000;
  localparam logic [30:0] Q29Two = 31'h4000_0000;

  // 21/(256*pi) in Q0.32.
  localparam logic [26:0] KernelConst = 27'd112147428;

  // One scaling step: floor(v * 2^24 / h), v and result 64 bit.
  localparam int NumBits      = 88;   // dividend width, v followed by 24 zeros
  localparam int OvfBits      = 24;   // quotient bits above 2^64
  localparam int BitsPerStage = 4;
  localparam int DivStages    = NumBits / BitsPerStage;

  // Scaling steps in the chain: kernel needs Dimensions, gradient two more.
  localparam int NumSteps = Dimensions + 2;

  localparam logic [47:0] WMax    = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] FSatVal = 48'h8000_0000_0000;

  // Partial restoring-division state of one lane.
  typedef struct packed {
    logic [31:0] rem;
    logic [87:0] nq;   // dividend bits shift out, quotient bits shift in
    logic        ovf;
  } div_lane_t;

  // Record handed from one scaling step to the next.
  typedef struct packed {
    logic        oos;
    logic [31:0] h;
    logic [63:0] a;
    logic        a_ovf;
    logic [63:0] b;
    logic        b_ovf;
  } div_val_t;

  // Four restoring iterations starting at dividend bit index base.
  function automatic div_lane_t div_iter(input div_lane_t l, input logic [31:0] h,
                                         input int base);
    div_lane_t  r;
    logic [32:0] rt;
    logic        qb;
    r = l;
    for (int j = 0; j < BitsPerStage; j++) begin
      rt = {r.rem, r.nq[NumBits-1]};
      qb = (rt >= {1'b0, h});
      if (qb) begin
        rt = rt - {1'b0, h};
      end
      r.nq  = {r.nq[NumBits-2:0], qb};
      r.rem = rt[31:0];
      if (base + j < OvfBits) begin
        r.ovf = r.ovf | qb;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/wke_div_step.sv =====
// ----------------------------------------------------------------------------
// wke_div_step: pipelined scaling step v <- floor(v * 2^24 / h)
// Two lanes share h; lane a may be set to pass through delayed.
// ----------------------------------------------------------------------------
`default_nettype none

module wke_div_step import wke_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     div_a_i,   // 0: lane a only delayed
  input  logic     valid_i,
  input  div_val_t item_i,
  output logic     valid_o,
  output div_val_t item_o
);

  div_lane_t   la_q [DivStages];
  div_lane_t   lb_q [DivStages];
  logic [31:0] h_q  [DivStages];
  logic        oos_q[DivStages];
  logic        vld_q[DivStages];

  div_lane_t   la_in [DivStages];
  div_lane_t   lb_in [DivStages];
  logic [31:0] h_in  [DivStages];
  logic        oos_in[DivStages];
  logic        vld_in[DivStages];

  div_lane_t la_last;
  div_lane_t lb_last;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign la_in[s]  = '{rem: '0, nq: {item_i.a, 24'b0}, ovf: item_i.a_ovf};
      assign lb_in[s]  = '{rem: '0, nq: {item_i.b, 24'b0}, ovf: item_i.b_ovf};
      assign h_in[s]   = item_i.h;
      assign oos_in[s] = item_i.oos;
      assign vld_in[s] = valid_i;
    end else begin : g_next
      assign la_in[s]  = la_q[s-1];
      assign lb_in[s]  = lb_q[s-1];
      assign h_in[s]   = h_q[s-1];
      assign oos_in[s] = oos_q[s-1];
      assign vld_in[s] = vld_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        la_q[s]  <= div_a_i ? div_iter(la_in[s], h_in[s], s * BitsPerStage) : la_in[s];
        lb_q[s]  <= div_iter(lb_in[s], h_in[s], s * BitsPerStage);
        h_q[s]   <= h_in[s];
        oos_q[s] <= oos_in[s];
      end
    end
  end

  assign la_last = la_q[DivStages-1];
  assign lb_last = lb_q[DivStages-1];

  // an overflowed step yields zero, later steps keep the flag
  always_comb begin
    item_o.oos   = oos_q[DivStages-1];
    item_o.h     = h_q[DivStages-1];
    item_o.a     = div_a_i ? (la_last.ovf ? 64'd0 : la_last.nq[63:0])
                           : la_last.nq[NumBits-1:OvfBits];
    item_o.a_ovf = la_last.ovf;
    item_o.b     = lb_last.ovf ? 64'd0 : lb_last.nq[63:0];
    item_o.b_ovf = lb_last.ovf;
  end

  assign valid_o = vld_q[DivStages-1];

endmodule

`default_nettype wire

// ===== design/wendland_kernel_eval.sv =====
// ----------------------------------------------------------------------------
// wendland_kernel_eval: Wendland C2 SPH kernel and gradient factor
// Streams particle pairs (r, h) in, kernel value and gradient factor out.
// ----------------------------------------------------------------------------
// One pair is taken per cycle and one result leaves per cycle while the
// output side is ready. The pipeline depth is set by the chain of
// pipelined dividers: one for q = r/h and DIMENSIONS+2 scaling steps by
// 1/h, each resolving four quotient bits per stage over 22 stages. A
// stall on the output freezes the whole pipeline, so nothing is lost
// or repeated. q = r/h is Q2.29, (2-q) powers are truncated at each
// product, results are Q16.32. Pairs with r > 2h, or h = 0, give zero
// results with out_of_support set; a clipped result sets saturated
// (kernel to all ones, gradient to -2^47).
// ----------------------------------------------------------------------------
`default_nettype none

module wendland_kernel_eval import wke_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] distance, [63:32] smoothing_length
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [95:0] m_axis_tdata_o,   // [47:0] kernel_value, [95:48] gradient_factor
  output logic [1:0]  m_axis_tuser_o    // [0] out_of_support, [1] saturated
);

  // Global advance: the pipeline moves whenever the output slot frees up.
  logic en;

  // Input stage: register the pair and decide support.
  logic        v0_q;
  logic [31:0] r0_q, h0_q;
  logic        oos0;

  // Division r/h.
  div_val_t d0_in, d0_out;
  logic     d0_vld;

  // Polynomial stages m1..m6.
  // (2-q)^3 reaches 8.0 and (2-q)^4 16.0 in Q2.29 at q = 0, so they carry
  // extra integer bits; 10*(2-q)^3 needs 36 bits.
  logic        v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic [31:0] h1_q, h2_q, h3_q, h4_q, h5_q, h6_q;
  logic        o1_q, o2_q, o3_q, o4_q, o5_q, o6_q;
  logic [30:0] q1_q, q2_q, q3_q, q4_q;
  logic [30:0] t1_q, t2t_q, t3t_q;
  logic [31:0] t2_q;
  logic [32:0] t3_q;
  logic [33:0] t4_q;
  logic [35:0] pf4_q, pf5_q;
  logic [34:0] pw5_q;
  logic [63:0] nw6_q, nf6_q;

  logic [61:0] p2;
  logic [61:0] p3;
  logic [62:0] p4;
  logic [31:0] mul5;
  logic [63:0] p5;
  logic [61:0] pw_c;
  logic [62:0] pf_c;

  // Scaling chain.
  div_val_t ch [NumSteps+1];
  logic     chv[NumSteps+1];

  // Output register.
  logic        m_valid_q;
  logic [47:0] kv_q, gf_q;
  logic        oos_q, sat_q;
  logic [34:0] wmag, fmag;
  div_val_t    fin;

  assign en              = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  assign oos0 = (h0_q == 32'd0) || ({1'b0, r0_q} > {h0_q, 1'b0});

  // ---- input register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r0_q <= s_axis_tdata_i[31:0];
      h0_q <= s_axis_tdata_i[63:32];
    end
  end

  // ---- q = floor(r * 2^29 / h) as one scaling step of r * 2^5 ----
  always_comb begin
    d0_in.oos   = oos0;
    d0_in.h     = h0_q;
    d0_in.a     = {27'b0, r0_q, 5'b0};
    d0_in.a_ovf = 1'b0;
    d0_in.b     = 64'd0;
    d0_in.b_ovf = 1'b0;
  end

  wke_div_step u_div_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .div_a_i (1'b1),
    .valid_i (v0_q),
    .item_i  (d0_in),
    .valid_o (d0_vld),
    .item_o  (d0_out)
  );

  // ---- polynomial in (2-q), registered over stages m1..m6 ----
  assign p2   = t1_q * t1_q;
  assign p3   = t2_q * t2t_q;
  assign p4   = t3_q * t3t_q;
  assign mul5 = Q29One + {q4_q, 1'b0};
  assign p5   = t4_q * mul5;
  assign pw_c = KernelConst * pw5_q;
  assign pf_c = KernelConst * pf5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= d0_vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // m1: t = 2 - q (q <= 2 inside support)
      q1_q  <= d0_out.a[30:0];
      t1_q  <= Q29Two - d0_out.a[30:0];
      h1_q  <= d0_out.h;
      o1_q  <= d0_out.oos;
      // m2: t^2
      t2_q  <= p2[FracBits+31:FracBits];
      t2t_q <= t1_q;
      q2_q  <= q1_q;
      h2_q  <= h1_q;
      o2_q  <= o1_q;
      // m3: t^3
      t3_q  <= p3[FracBits+32:FracBits];
      t3t_q <= t2t_q;
      q3_q  <= q2_q;
      h3_q  <= h2_q;
      o3_q  <= o2_q;
      // m4: t^4 and 10*t^3
      t4_q  <= p4[FracBits+33:FracBits];
      pf4_q <= ({3'b0, t3_q} << 3) + ({3'b0, t3_q} << 1);
      q4_q  <= q3_q;
      h4_q  <= h3_q;
      o4_q  <= o3_q;
      // m5: t^4 * (1 + 2q)
      pw5_q <= p5[FracBits+34:FracBits];
      pf5_q <= pf4_q;
      h5_q  <= h4_q;
      o5_q  <= o4_q;
      // m6: times the normalization constant
      nw6_q <= {2'b0, pw_c};
      nf6_q <= {1'b0, pf_c};
      h6_q  <= h5_q;
      o6_q  <= o5_q;
    end
  end

  // ---- scaling chain: lane a (kernel) divides in the first Dimensions steps,
  //      lane b (gradient) in all of them ----
  always_comb begin
    ch[0].oos   = o6_q;
    ch[0].h     = h6_q;
    ch[0].a     = nw6_q;
    ch[0].a_ovf = 1'b0;
    ch[0].b     = nf6_q;
    ch[0].b_ovf = 1'b0;
  end
  assign chv[0] = v6_q;

  for (genvar k = 0; k < NumSteps; k++) begin : g_scale
    wke_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .div_a_i ((k < Dimensions) ? 1'b1 : 1'b0),
      .valid_i (chv[k]),
      .item_i  (ch[k]),
      .valid_o (chv[k+1]),
      .item_o  (ch[k+1])
    );
  end

  // ---- drop the extra fraction bits, saturate, register the result ----
  assign fin  = ch[NumSteps];
  assign wmag = fin.a[63:FracBits];
  assign fmag = fin.b[63:FracBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= chv[NumSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oos_q <= fin.oos;
      sat_q <= !fin.oos && (fin.a_ovf || fin.b_ovf);
      if (fin.oos) begin
        kv_q <= 48'd0;
        gf_q <= 48'd0;
      end else begin
        kv_q <= fin.a_ovf ? WMax : {13'b0, wmag};
        gf_q <= fin.b_ovf ? FSatVal : (48'd0 - {13'b0, fmag});
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {gf_q, kv_q};
  assign m_axis_tuser_o  = {sat_q, oos_q};

  // ---- checks ----
  a_oos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && oos_q |-> kv_q == 48'd0 && gf_q == 48'd0 && !sat_q)
    else $error("out-of-support result not zero");

  a_grad_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && gf_q != 48'd0 |-> gf_q[47])
    else $error("gradient factor positive");

  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && sat_q |-> kv_q == WMax || gf_q == FSatVal)
    else $error("saturated without clipped result");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v6_q) && $stable(chv[NumSteps]))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the Wendland C2 kernel evaluator
// Streams (r, h) pairs into the block with random idle and stall bursts,
// predicts the kernel value, gradient factor and flags of each pair, and
// compares every output transfer against the oldest prediction in order.
// ----------------------------------------------------------------------------
module tb_top;
  import wke_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FBits = 29;
  localparam longint unsigned KConst = 64'd112147428;
  localparam longint unsigned WTop = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned FTop = 64'h8000_0000_0000;
  localparam int DrainCycles = 300;   // well past the pipeline depth

  typedef struct packed {
    logic [47:0] kernel;
    logic [47:0] grad;
    logic        oos;
    logic        sat;
  } kernel_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;   // [31:0] distance, [63:32] smoothing_length
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [95:0] m_axis_tdata_o;        // [47:0] kernel_value, [95:48] gradient_factor
  logic [1:0]  m_axis_tuser_o;        // [0] out_of_support, [1] saturated

  kernel_out_t pending_q[$];
  int          errors = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;

  wendland_kernel_eval dut (.*);

  always #6 clk_i = ~clk_i;

  // floor(v * 2^24 / h) with 64-bit overflow detection
  function automatic longint unsigned inv_h_scale(input longint unsigned v,
                                                  input longint unsigned h,
                                                  inout bit ovf);
    longint unsigned whole, rem;
    if (ovf) return 0;
    whole = v / h;
    rem   = v % h;
    if (whole >= (64'd1 << 40)) begin
      ovf = 1'b1;
      return 0;
    end
    return (whole << 24) + ((rem << 24) / h);
  endfunction

  function automatic kernel_out_t wendland_predict(input logic [31:0] rdist,
                                                   input logic [31:0] hlen);
    kernel_out_t     res;
    longint unsigned r, h, q, t, t2, t3, t4, pw, pf, wv, fv;
    bit              ow, of;
    r = rdist;
    h = hlen;
    ow = 0;
    of = 0;
    res = '0;
    if (h == 0 || r > 2 * h) begin
      res.oos = 1'b1;
      return res;
    end
    q  = (r << FBits) / h;
    t  = (64'd1 << (FBits + 1)) - q;
    t2 = (t * t) >> FBits;
    t3 = (t2 * t) >> FBits;
    t4 = (t3 * t) >> FBits;
    pw = (t4 * ((64'd1 << FBits) + 2 * q)) >> FBits;
    pf = 10 * t3;
    wv = KConst * pw;
    fv = KConst * pf;
    for (int i = 0; i < Dimensions; i++) wv = inv_h_scale(wv, h, ow);
    for (int i = 0; i < Dimensions + 2; i++) fv = inv_h_scale(fv, h, of);
    wv = wv >> FBits;
    fv = fv >> FBits;
    if (ow || wv > WTop) begin
      wv = WTop;
      res.sat = 1'b1;
    end
    if (of || fv > FTop) begin
      fv = FTop;
      res.sat = 1'b1;
    end
    res.kernel = wv[47:0];
    res.grad   = 48'(64'd0 - fv);
    return res;
  endfunction

  // One pair: optional idle burst, then hold tvalid until the transfer.
  task automatic send_pair(input logic [31:0] rdist, input logic [31:0] hlen);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {hlen, rdist};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_q = {pending_q, wendland_predict(rdist, hlen)};
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_h();
    logic [31:0] h;
    h = $urandom >> $urandom_range(0, 31);
    return (h == 0) ? 32'd1 : h;
  endfunction

  // r drawn uniformly from [0, 2h], clipped to the 32-bit maximum
  function automatic logic [31:0] rand_r_inside(input logic [31:0] h);
    longint unsigned v;
    v = {$urandom, $urandom} % (2 * longint'(h) + 1);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  task automatic test_directed();
    send_pair(32'd0, 32'd1);                   // q = 0, tiny h: saturates
    send_pair(32'd0, 32'hFFFF_FFFF);           // q = 0, largest h
    send_pair(32'd0, 32'h0100_0000);           // h = 1.0, kernel peak
    send_pair(32'h0200_0000, 32'h0100_0000);   // support edge r = 2h
    send_pair(32'h0200_0001, 32'h0100_0000);   // just past the edge
    send_pair(32'h7FFF_FFFF, 32'h3FFF_FFFF);   // just past the edge, odd h
    send_pair(32'hFFFF_FFFF, 32'h7FFF_FFFF);   // just outside, large values
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // q = 1
    send_pair(32'hFFFF_FFFF, 32'd1);           // far outside
    send_pair(32'd0, 32'd0);                   // zero h
    send_pair(32'h1234_5678, 32'd0);           // zero h, nonzero r
    send_pair(32'd2, 32'd1);                   // edge at smallest h
    send_pair(32'd1, 32'd1);
    send_pair(32'h0080_0000, 32'h0100_0000);   // q = 0.5
    send_pair(32'h0180_0000, 32'h0100_0000);   // q = 1.5
    send_pair(32'h0000_0100, 32'h0000_1000);   // small h, saturating region
    send_pair(32'h0010_0000, 32'h0020_0000);
    send_pair(32'h5555_5555, 32'hAAAA_AAAA);
    send_pair(32'hAAAA_AAAA, 32'h5555_5555);
    send_pair(32'h1FFF_FFFF, 32'h0FFF_FFFF);   // just past the edge, mid-range values
  endtask

  task automatic test_random_inside(input int n);
    logic [31:0] h;
    repeat (n) begin
      h = rand_h();
      send_pair(rand_r_inside(h), h);
    end
  endtask

  task automatic test_random_any(input int n);
    logic [31:0] h;
    repeat (n) begin
      h = ($urandom_range(0, 15) == 0) ? $urandom : rand_h();
      send_pair($urandom >> $urandom_range(0, 8), h);
    end
  endtask

  task automatic test_full_rate(input int n);
    logic [31:0] h;
    idle_on = 1'b0;
    repeat (n) begin
      h = rand_h();
      send_pair(rand_r_inside(h), h);
    end
  endtask

  // Output side: random ready bursts and stall bursts (stalls only while idle_on is set).
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Check each output transfer against the oldest prediction.
  always @(posedge clk_i) begin
    kernel_out_t exp_r, got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tdata_o[47:0], m_axis_tdata_o[95:48],
             m_axis_tuser_o[0], m_axis_tuser_o[1]};
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transfer: %h", got);
      end else begin
        exp_r = pending_q.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp k=%h g=%h oos=%b sat=%b got k=%h g=%h oos=%b sat=%b",
                     exp_r.kernel, exp_r.grad, exp_r.oos, exp_r.sat,
                     got.kernel, got.grad, got.oos, got.sat);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_inside(700);
    test_random_any(200);
    test_full_rate(130);
    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
